// ----- rtl/uyvy_to_rgb565_converter_top_assert.svh -----
// Assertion macros for the UYVY to RGB565 converter.
`ifndef UYVY_TO_RGB565_CONVERTER_TOP_ASSERT_SVH
`define UYVY_TO_RGB565_CONVERTER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked check, suspended while reset is high.
`define U2R_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("u2r assertion failed");
// Clocked check that also holds through reset.
`define U2R_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("u2r assertion failed");
`else
`define U2R_ASSERT(label, prop)
`define U2R_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ----- rtl/u2r_pkg.sv -----
// Shared types, coefficients and pixel packing for the UYVY to RGB565 converter.
`default_nettype none
package u2r_pkg;

  // BT.601 full-range coefficients, signed Q2.16 fixed point (18 bits, 16 fraction bits)
  localparam logic signed [17:0] COEF_RV = 18'sd91881;
  localparam logic signed [17:0] COEF_GV = -18'sd46802;
  localparam logic signed [17:0] COEF_GU = 18'sd22553;
  localparam logic signed [17:0] COEF_BU = 18'sd116130;

  localparam int unsigned PROD_W = 25;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned OFF_W  = PROD_W - FRAC_W;
  localparam int unsigned SUM_W  = 11;

  // Per-channel chroma offsets shared by both pixels of a word
  typedef struct packed {
    logic                    valid;
    logic signed [OFF_W-1:0] r_off;
    logic signed [OFF_W-1:0] g_off;
    logic signed [OFF_W-1:0] b_off;
  } offs_t;

  // Clamp a signed channel sum to 0..255
  function automatic logic [7:0] clamp_byte(input logic signed [SUM_W-1:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > 255) begin
      res = 8'hff;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  // Add luma to each offset, clamp, and pack into RGB565
  function automatic logic [15:0] pack565(input logic [7:0] y, input offs_t o);
    logic signed [SUM_W-1:0] ys;
    logic [7:0] rc;
    logic [7:0] gc;
    logic [7:0] bc;
    ys = $signed({{(SUM_W-8){1'b0}}, y});
    rc = clamp_byte(ys + SUM_W'(o.r_off));
    gc = clamp_byte(ys + SUM_W'(o.g_off));
    bc = clamp_byte(ys + SUM_W'(o.b_off));
    return {rc[7:3], gc[7:2], bc[7:3]};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/u2r_chroma.sv -----
// Chroma path: coefficient products, then offsets floored from the Q9.16 products, two stages.
`default_nettype none
module u2r_chroma
  import u2r_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic signed [7:0] cb,
  input  wire logic signed [7:0] cr,
  output offs_t                 offs
);

  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod_rv;
  logic signed [PROD_W-1:0] prod_gv;
  logic signed [PROD_W-1:0] prod_gu;
  logic signed [PROD_W-1:0] prod_bu;
  logic signed [PROD_W-1:0] g_sum;

  // Stage A: four narrow constant multiplies
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= in_valid;
    end
    prod_rv <= PROD_W'(cr) * PROD_W'(COEF_RV);
    prod_gv <= PROD_W'(cr) * PROD_W'(COEF_GV);
    prod_gu <= PROD_W'(cb) * PROD_W'(COEF_GU);
    prod_bu <= PROD_W'(cb) * PROD_W'(COEF_BU);
  end

  assign g_sum = prod_gv - prod_gu;

  // Stage B: green sum, drop fraction bits (arithmetic, floors)
  always_ff @(posedge clk) begin
    if (rst) begin
      offs.valid <= 1'b0;
    end else begin
      offs.valid <= prod_valid;
    end
    offs.r_off <= prod_rv[PROD_W-1:FRAC_W];
    offs.g_off <= g_sum[PROD_W-1:FRAC_W];
    offs.b_off <= prod_bu[PROD_W-1:FRAC_W];
  end

endmodule
`default_nettype wire

// ----- rtl/uyvy_to_rgb565_converter_top.sv -----
// Top level of the UYVY to RGB565 converter: input stage, chroma path, pack stage.
//
//  channel | ports                                        | beat marked by
//  --------+----------------------------------------------+-------------------
//  input   | chroma_u luma_first chroma_v luma_second     | start && !busy
//  result  | pixel_first pixel_second                     | done (one cycle)
//
// One beat is taken every cycle through four register stages (input, products,
// offsets, pack); busy stays low and the pipeline never stalls. The receiver
// must take each result in the cycle it appears; the block does not enforce it.
// Reset clears the stage valid bits only; data registers are not reset.
`default_nettype none
`include "uyvy_to_rgb565_converter_top_assert.svh"
module uyvy_to_rgb565_converter_top
  import u2r_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  chroma_u,
  input  wire logic [7:0]  luma_first,
  input  wire logic [7:0]  chroma_v,
  input  wire logic [7:0]  luma_second,
  output logic             done,
  output logic [15:0]      pixel_first,
  output logic [15:0]      pixel_second
);

  logic              in_valid;
  logic signed [7:0] cb;
  logic signed [7:0] cr;
  logic [7:0]        y0_s1;
  logic [7:0]        y1_s1;
  logic [7:0]        y0_s2;
  logic [7:0]        y1_s2;
  logic [7:0]        y0_s3;
  logic [7:0]        y1_s3;
  offs_t             offs;

  assign busy = 1'b0;

  // Input stage: remove chroma bias by flipping the top bit
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    cb    <= $signed({~chroma_u[7], chroma_u[6:0]});
    cr    <= $signed({~chroma_v[7], chroma_v[6:0]});
    y0_s1 <= luma_first;
    y1_s1 <= luma_second;
  end

  u2r_chroma u_chroma (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cb       (cb),
    .cr       (cr),
    .offs     (offs)
  );

  // Luma delay to line up with the chroma offsets
  always_ff @(posedge clk) begin
    y0_s2 <= y0_s1;
    y1_s2 <= y1_s1;
    y0_s3 <= y0_s2;
    y1_s3 <= y1_s2;
  end

  // Pack stage: add luma, clamp, truncate to 565
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= offs.valid;
    end
    pixel_first  <= pack565(y0_s3, offs);
    pixel_second <= pack565(y1_s3, offs);
  end

  // Every accepted beat gives a result after the four register stages, and only then
  `U2R_ASSERT(a_latency, (start && !busy) |-> ##4 done)
  `U2R_ASSERT(a_no_spurious, done |-> $past(start && !busy, 4))
  // Neutral chroma passes luma straight through to all three channels of pixel_first
  `U2R_ASSERT(a_gray, (done && $past(chroma_u == 8'd128 && chroma_v == 8'd128, 4)) |-> (pixel_first == {$past(luma_first[7:3], 4), $past(luma_first[7:2], 4), $past(luma_first[7:3], 4)}))
  `U2R_ASSERT_ALWAYS(a_reset_clears, rst |=> !done)

endmodule
`default_nettype wire
